/* rtl/core/vtte_pkg.sv */
// Shared types, character codes and status codes of the text expander.
`timescale 1ns / 1ps
package vtte_pkg;

	localparam int NAME_W  = 56;
	localparam int LEN_W   = 3;
	localparam int CHAR_W  = 8;
	localparam int LIMIT_W = 13;
	localparam int COUNT_W = 12;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd256;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 13'd4096;
	localparam logic [COUNT_W-1:0] CAP_MAX     = 12'd4095;

	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
	localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_NAME  = 3'd1,
		ST_BAD_VALUE = 3'd2,
		ST_FULL      = 3'd3,
		ST_NAME_LONG = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_TEXT   = 2'd0,
		MODE_DOLLAR = 2'd1,
		MODE_BARE   = 2'd2,
		MODE_BRACED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EM_CHAR      = 3'd0,
		EM_VAL       = 3'd1,
		EM_NIL       = 3'd2,
		EM_TEXT_DONE = 3'd3,
		EM_SET_DONE  = 3'd4
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      scan_clr;
		logic      scan_step;
		logic      k_clr;
		logic      k_inc;
		logic      rd_val;
		logic      rd_stg;
		logic      wr_val;
		logic      commit_slot;
		logic      delete_slot;
		logic      set_mode;
		mode_t     mode_val;
		logic      append;
		logic      clr_ref;
		logic      set_trunc;
		logic      emit;
		emit_sel_t emit_sel;
		logic      text_clear;
		logic      stage_clear;
		logic      set_status;
		status_t   status_val;
		logic      finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic  is_expand;
		logic  fin;
		logic  aborted;
		logic  trunc;
		mode_t mode;
		logic  c_dollar;
		logic  c_lbrace;
		logic  c_name_bare;
		logic  c_name_braced;
		logic  full;
		logic  ref_empty;
		logic  scan_last;
		logic  found_v;
		logic  empty_v;
		logic  is_nil;
		logic  name_bad;
		logic  value_bad;
		logic  k_last_val;
		logic  k_last_stg;
		logic  k_last_nil;
		logic  can_emit;
		logic  hold_v;
		logic  out_free;
	} dp_sts_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic               cv;
		status_t            st;
		logic               td;
		logic [COUNT_W-1:0] cnt;
	} res_t;

endpackage

/* rtl/core/vtte_dp.sv */
// Datapath of the text expander: variable table, staging buffer, parser state, result stage.
`timescale 1ns / 1ps
module vtte_dp #(
	parameter int ENTRIES   = 16,
	parameter int NAME_LEN  = 8,
	parameter int VALUE_LEN = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vtte_pkg::ctl_cmd_t                cmd,
	output vtte_pkg::dp_sts_t                 sts,
	input  logic                              command,
	input  logic [vtte_pkg::NAME_W-1:0]       name_chars,
	input  logic [vtte_pkg::LEN_W-1:0]        name_length,
	input  logic [vtte_pkg::CHAR_W-1:0]       character,
	input  logic                              final_req,
	input  logic                              cfg_we,
	input  logic [vtte_pkg::LIMIT_W-1:0]      cfg_wdata,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [vtte_pkg::CHAR_W-1:0]       out_char,
	output logic                              char_valid,
	output logic                              run_last,
	output logic [2:0]                        status,
	output logic                              text_done,
	output logic [vtte_pkg::COUNT_W-1:0]      output_count
);

	localparam int NW  = 8 * (NAME_LEN - 1);
	localparam int RLW = $clog2(NAME_LEN);
	localparam int VLW = $clog2(VALUE_LEN);
	localparam int SLW = $clog2(VALUE_LEN + 1);
	localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AW  = $clog2(ENTRIES * VALUE_LEN);

	// Item registers
	logic                          is_expand_q, fin_q;
	logic [vtte_pkg::CHAR_W-1:0]   c_q;
	logic [NW-1:0]                 nm_q;
	logic                          nm_bad_q;
	logic [NW-1:0]                 nm_mask;
	logic                          nm_bad;

	// Configuration
	logic [vtte_pkg::LIMIT_W-1:0]  lim_q;
	logic [vtte_pkg::COUNT_W-1:0]  cap;

	// Parser state
	vtte_pkg::mode_t               mode_q;
	logic [NW-1:0]                 ref_name_q;
	logic [RLW-1:0]                ref_len_q;
	logic [vtte_pkg::COUNT_W-1:0]  emitted_q;
	logic                          aborted_q, trunc_q;

	// Staging of a set value
	logic [vtte_pkg::CHAR_W-1:0]   stg_mem [VALUE_LEN];
	logic [SLW-1:0]                stg_len_q;
	logic                          stg_bad_q;
	logic [vtte_pkg::CHAR_W-1:0]   f0_q, f1_q, f2_q;
	logic [vtte_pkg::CHAR_W-1:0]   stg_rd_q;

	// Table
	logic [NW-1:0]                 names_mem [ENTRIES];
	logic [VLW-1:0]                lens_mem [ENTRIES];
	logic [vtte_pkg::CHAR_W-1:0]   val_mem [ENTRIES * VALUE_LEN];
	logic [ENTRIES-1:0]            used_q;
	logic [vtte_pkg::CHAR_W-1:0]   val_rd_q;

	// Scan
	logic [EW-1:0]                 idx_q, idx_s1;
	logic                          vld_s1, used_s1;
	logic [NW-1:0]                 name_s1;
	logic [VLW-1:0]                len_s1;
	logic [EW-1:0]                 found_q, empty_q, slot;
	logic                          found_v_q, empty_v_q;
	logic [VLW-1:0]                len_found_q;
	logic [NW-1:0]                 key;
	logic [VLW-1:0]                k_q;
	logic [AW-1:0]                 val_addr;

	// Results
	vtte_pkg::status_t             status_q, text_st;
	vtte_pkg::res_t                res_new, hold_q, out_q;
	logic                          hold_v_q, out_v_q, out_last_q;
	logic                          out_free, push;
	logic                          c_print;

	always_comb begin
		nm_mask = '0;
		nm_bad  = (name_length == '0) || (4'(name_length) >= 4'(NAME_LEN));
		for (int i = 0; i < NAME_LEN - 1; i++) begin
			if (vtte_pkg::LEN_W'(i) < name_length) begin
				nm_mask[8*i +: 8] = name_chars[8*i +: 8];
				if (name_chars[8*i +: 8] == '0) begin
					nm_bad = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (lim_q == '0) begin
			cap = '0;
		end else if (lim_q > vtte_pkg::LIMIT_MAX) begin
			cap = vtte_pkg::CAP_MAX;
		end else begin
			cap = vtte_pkg::COUNT_W'(lim_q - 1'b1);
		end
	end

	assign c_print  = (c_q >= vtte_pkg::CH_SPACE) && (c_q <= vtte_pkg::CH_TILDE);
	assign slot     = found_v_q ? found_q : empty_q;
	assign key      = is_expand_q ? ref_name_q : nm_q;
	assign val_addr = AW'(slot) * AW'(VALUE_LEN) + AW'(k_q);
	assign out_free = !out_v_q || out_ready;
	assign push     = (cmd.emit && hold_v_q) || cmd.finish;
	assign text_st  = aborted_q ? vtte_pkg::ST_NAME_LONG :
	                  (trunc_q ? vtte_pkg::ST_TRUNC : vtte_pkg::ST_OK);

	always_comb begin
		sts.is_expand     = is_expand_q;
		sts.fin           = fin_q;
		sts.aborted       = aborted_q;
		sts.trunc         = trunc_q;
		sts.mode          = mode_q;
		sts.c_dollar      = (c_q == vtte_pkg::CH_DOLLAR);
		sts.c_lbrace      = (c_q == vtte_pkg::CH_LBRACE);
		sts.c_name_bare   = c_print && (c_q != vtte_pkg::CH_SPACE);
		sts.c_name_braced = c_print && (c_q != vtte_pkg::CH_RBRACE);
		sts.full          = (emitted_q >= cap);
		sts.ref_empty     = (ref_len_q == '0);
		sts.scan_last     = (idx_q == EW'(ENTRIES - 1));
		sts.found_v       = found_v_q;
		sts.empty_v       = empty_v_q;
		sts.is_nil        = (stg_len_q == SLW'(3)) && (f0_q == vtte_pkg::CH_N) &&
		                    (f1_q == vtte_pkg::CH_I) && (f2_q == vtte_pkg::CH_L);
		sts.name_bad      = nm_bad_q;
		sts.value_bad     = stg_bad_q || (stg_len_q == '0) || (stg_len_q >= SLW'(VALUE_LEN));
		sts.k_last_val    = ((k_q + VLW'(1)) == len_found_q);
		sts.k_last_stg    = ((SLW'(k_q) + SLW'(1)) == stg_len_q);
		sts.k_last_nil    = (k_q == VLW'(2));
		sts.can_emit      = !hold_v_q || out_free;
		sts.hold_v        = hold_v_q;
		sts.out_free      = out_free;
	end

	always_comb begin
		res_new = '0;
		case (cmd.emit_sel)
			vtte_pkg::EM_CHAR: begin
				res_new.ch  = c_q;
				res_new.cv  = 1'b1;
				res_new.cnt = emitted_q + 1'b1;
			end
			vtte_pkg::EM_VAL: begin
				res_new.ch  = val_rd_q;
				res_new.cv  = 1'b1;
				res_new.cnt = emitted_q + 1'b1;
			end
			vtte_pkg::EM_NIL: begin
				res_new.ch  = (k_q == '0) ? vtte_pkg::CH_N :
				              ((k_q == VLW'(1)) ? vtte_pkg::CH_I : vtte_pkg::CH_L);
				res_new.cv  = 1'b1;
				res_new.cnt = emitted_q + 1'b1;
			end
			vtte_pkg::EM_TEXT_DONE: begin
				res_new.st  = text_st;
				res_new.td  = 1'b1;
				res_new.cnt = emitted_q;
			end
			vtte_pkg::EM_SET_DONE: begin
				res_new.st  = status_q;
				res_new.td  = 1'b1;
			end
			default: begin
				res_new = '0;
			end
		endcase
	end

	// Item capture and staging
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_expand_q <= command;
			fin_q       <= final_req;
			c_q         <= character;
			nm_q        <= nm_mask;
			nm_bad_q    <= nm_bad;
			if (!command && (stg_len_q < SLW'(VALUE_LEN))) begin
				stg_mem[stg_len_q[VLW-1:0]] <= character;
			end
		end
		if (cmd.rd_stg) begin
			stg_rd_q <= stg_mem[k_q];
		end
		if (cmd.accept && !command) begin
			if (stg_len_q == SLW'(0)) f0_q <= character;
			if (stg_len_q == SLW'(1)) f1_q <= character;
			if (stg_len_q == SLW'(2)) f2_q <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_len_q <= '0;
			stg_bad_q <= 1'b0;
		end else if (cmd.stage_clear) begin
			stg_len_q <= '0;
			stg_bad_q <= 1'b0;
		end else if (cmd.accept && !command) begin
			if (stg_len_q < SLW'(VALUE_LEN)) begin
				stg_len_q <= stg_len_q + 1'b1;
			end
			if (character == '0) begin
				stg_bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= vtte_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vtte_pkg::MODE_TEXT;
			ref_name_q <= '0;
			ref_len_q  <= '0;
			emitted_q  <= '0;
			aborted_q  <= 1'b0;
			trunc_q    <= 1'b0;
		end else begin
			if (cmd.set_mode) begin
				mode_q <= cmd.mode_val;
			end
			if (cmd.append) begin
				if (ref_len_q == RLW'(NAME_LEN - 1)) begin
					aborted_q  <= 1'b1;
					ref_name_q <= '0;
					ref_len_q  <= '0;
					mode_q     <= vtte_pkg::MODE_TEXT;
				end else begin
					ref_name_q <= ref_name_q | (NW'(c_q) << (8 * ref_len_q));
					ref_len_q  <= ref_len_q + 1'b1;
				end
			end
			if (cmd.clr_ref) begin
				ref_name_q <= '0;
				ref_len_q  <= '0;
				mode_q     <= vtte_pkg::MODE_TEXT;
			end
			if (cmd.set_trunc) begin
				trunc_q <= 1'b1;
			end
			if (cmd.emit && res_new.cv) begin
				emitted_q <= emitted_q + 1'b1;
			end
			if (cmd.text_clear) begin
				ref_name_q <= '0;
				ref_len_q  <= '0;
				mode_q     <= vtte_pkg::MODE_TEXT;
				emitted_q  <= '0;
				aborted_q  <= 1'b0;
				trunc_q    <= 1'b0;
			end
		end
	end

	// Table memories
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			name_s1 <= names_mem[idx_q];
			len_s1  <= lens_mem[idx_q];
		end
		if (cmd.commit_slot) begin
			names_mem[slot] <= nm_q;
			lens_mem[slot]  <= stg_len_q[VLW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_val) begin
			val_mem[val_addr] <= stg_rd_q;
		end
		if (cmd.rd_val) begin
			val_rd_q <= val_mem[val_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit_slot) begin
			used_q[slot] <= 1'b1;
		end else if (cmd.delete_slot) begin
			used_q[slot] <= 1'b0;
		end
	end

	// Slot scan: read one slot per cycle, compare it in the next cycle
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		used_s1 <= used_q[idx_q];
		if (vld_s1 && used_s1 && (name_s1 == key)) begin
			found_q     <= idx_s1;
			len_found_q <= len_s1;
		end
		if (vld_s1 && !used_s1 && !empty_v_q) begin
			empty_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			vld_s1    <= 1'b0;
			found_v_q <= 1'b0;
			empty_v_q <= 1'b0;
			k_q       <= '0;
		end else begin
			vld_s1 <= cmd.scan_step;
			if (cmd.scan_clr) begin
				idx_q     <= '0;
				found_v_q <= 1'b0;
				empty_v_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (vld_s1 && used_s1 && (name_s1 == key)) begin
					found_v_q <= 1'b1;
				end
				if (vld_s1 && !used_s1) begin
					empty_v_q <= 1'b1;
				end
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Result stage: one held result waits until the next one shows whether it is the last
	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			status_q <= cmd.status_val;
		end
		if (cmd.emit) begin
			hold_q <= res_new;
		end
		if (push) begin
			out_q      <= hold_q;
			out_last_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				hold_v_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_v_q;
	assign out_char     = out_q.ch;
	assign char_valid   = out_q.cv;
	assign run_last     = out_last_q;
	assign status       = out_q.st;
	assign text_done    = out_q.td;
	assign output_count = out_q.cnt;

endmodule

/* rtl/core/vtte_ctrl.sv */
// Sequencing state machine of the text expander.
`timescale 1ns / 1ps
module vtte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic               final_req,
	input  vtte_pkg::dp_sts_t  sts,
	output vtte_pkg::ctl_cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_DEC   = 17'b00000000000000010,
		S_TOP   = 17'b00000000000000100,
		S_SCAN  = 17'b00000000000001000,
		S_STAIL = 17'b00000000000010000,
		S_RSEL  = 17'b00000000000100000,
		S_RRD   = 17'b00000000001000000,
		S_REM   = 17'b00000000010000000,
		S_NIL   = 17'b00000000100000000,
		S_FIN   = 17'b00000001000000000,
		S_DONE  = 17'b00000010000000000,
		S_SCHK  = 17'b00000100000000000,
		S_SDEC  = 17'b00001000000000000,
		S_SRD   = 17'b00010000000000000,
		S_SWR   = 17'b00100000000000000,
		S_SDONE = 17'b01000000000000000,
		S_END   = 17'b10000000000000000
	} state_t;

	typedef enum logic [1:0] {
		RET_TOP  = 2'd0,
		RET_FIN  = 2'd1,
		RET_DONE = 2'd2
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	state_t ret_state;

	always_comb begin
		case (ret_q)
			RET_TOP:  ret_state = S_TOP;
			RET_FIN:  ret_state = S_FIN;
			default:  ret_state = S_DONE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (command) begin
						state_d = S_DEC;
					end else if (final_req) begin
						state_d = S_SCHK;
					end
				end
			end
			S_DEC: begin
				if (sts.aborted || sts.trunc) begin
					state_d = S_FIN;
				end else if (sts.mode == vtte_pkg::MODE_TEXT) begin
					state_d = S_TOP;
				end else if ((sts.mode == vtte_pkg::MODE_DOLLAR) && sts.c_lbrace) begin
					cmd.set_mode = 1'b1;
					cmd.mode_val = vtte_pkg::MODE_BRACED;
					state_d      = S_FIN;
				end else if (sts.mode == vtte_pkg::MODE_BRACED) begin
					if (sts.c_name_braced) begin
						cmd.append = 1'b1;
						state_d    = S_FIN;
					end else begin
						cmd.scan_clr = 1'b1;
						ret_d        = RET_FIN;
						state_d      = S_SCAN;
					end
				end else begin
					cmd.set_mode = 1'b1;
					cmd.mode_val = vtte_pkg::MODE_BARE;
					if (sts.c_name_bare) begin
						cmd.append = 1'b1;
						state_d    = S_FIN;
					end else begin
						cmd.scan_clr = 1'b1;
						ret_d        = RET_TOP;
						state_d      = S_SCAN;
					end
				end
			end
			S_TOP: begin
				if (sts.aborted || sts.trunc) begin
					state_d = S_FIN;
				end else if (sts.full) begin
					cmd.set_trunc = 1'b1;
					state_d       = S_FIN;
				end else if (sts.c_dollar) begin
					cmd.set_mode = 1'b1;
					cmd.mode_val = vtte_pkg::MODE_DOLLAR;
					state_d      = S_FIN;
				end else if (sts.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = vtte_pkg::EM_CHAR;
					state_d      = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_STAIL;
				end
			end
			S_STAIL: begin
				state_d = sts.is_expand ? S_RSEL : S_SDEC;
			end
			S_RSEL: begin
				cmd.k_clr = 1'b1;
				state_d   = (sts.found_v && !sts.ref_empty) ? S_RRD : S_NIL;
			end
			S_RRD: begin
				if (sts.full) begin
					cmd.set_trunc = 1'b1;
					cmd.clr_ref   = 1'b1;
					state_d       = ret_state;
				end else begin
					cmd.rd_val = 1'b1;
					state_d    = S_REM;
				end
			end
			S_REM: begin
				if (sts.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = vtte_pkg::EM_VAL;
					cmd.k_inc    = 1'b1;
					if (sts.k_last_val) begin
						cmd.clr_ref = 1'b1;
						state_d     = ret_state;
					end else begin
						state_d = S_RRD;
					end
				end
			end
			S_NIL: begin
				if (sts.full) begin
					cmd.set_trunc = 1'b1;
					cmd.clr_ref   = 1'b1;
					state_d       = ret_state;
				end else if (sts.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = vtte_pkg::EM_NIL;
					cmd.k_inc    = 1'b1;
					if (sts.k_last_nil) begin
						cmd.clr_ref = 1'b1;
						state_d     = ret_state;
					end
				end
			end
			S_FIN: begin
				if (!sts.fin) begin
					state_d = S_END;
				end else if (!sts.aborted && !sts.trunc &&
				             (sts.mode != vtte_pkg::MODE_TEXT)) begin
					cmd.scan_clr = 1'b1;
					ret_d        = RET_DONE;
					state_d      = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.can_emit) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = vtte_pkg::EM_TEXT_DONE;
					cmd.text_clear = 1'b1;
					state_d        = S_END;
				end
			end
			S_SCHK: begin
				cmd.set_status = 1'b1;
				if (sts.name_bad) begin
					cmd.status_val = vtte_pkg::ST_BAD_NAME;
					state_d        = S_SDONE;
				end else if (sts.value_bad) begin
					cmd.status_val = vtte_pkg::ST_BAD_VALUE;
					state_d        = S_SDONE;
				end else begin
					cmd.status_val = vtte_pkg::ST_OK;
					cmd.scan_clr   = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SDEC: begin
				if (!sts.found_v && !sts.empty_v) begin
					cmd.set_status = 1'b1;
					cmd.status_val = vtte_pkg::ST_FULL;
					state_d        = S_SDONE;
				end else if (sts.is_nil) begin
					cmd.delete_slot = 1'b1;
					state_d         = S_SDONE;
				end else begin
					cmd.k_clr = 1'b1;
					state_d   = S_SRD;
				end
			end
			S_SRD: begin
				cmd.rd_stg = 1'b1;
				state_d    = S_SWR;
			end
			S_SWR: begin
				cmd.wr_val = 1'b1;
				cmd.k_inc  = 1'b1;
				if (sts.k_last_stg) begin
					cmd.commit_slot = 1'b1;
					state_d         = S_SDONE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SDONE: begin
				if (sts.can_emit) begin
					cmd.emit        = 1'b1;
					cmd.emit_sel    = vtte_pkg::EM_SET_DONE;
					cmd.stage_clear = 1'b1;
					state_d         = S_END;
				end
			end
			S_END: begin
				if (!sts.hold_v) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_TOP;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

/* rtl/core/variable_table_text_expander.sv */
// Top level of the variable table text expander.
`timescale 1ns / 1ps
// The block keeps a table of named text variables and expands $name and ${name}
// references in a character stream. Items enter on the in_valid/in_ready channel:
// command 0 is one value character of a set (the item with final_req high commits
// it), command 1 is one text character. Results leave on the out_valid/out_ready
// channel, one transfer per emitted character plus one status transfer that ends
// each set or text; run_last marks the final transfer caused by an input item.
// The block works on one item at a time. A reference is resolved by walking the
// slots one per cycle and then reading the value memory, one emitted character at
// a time, through its single port. A committed set walks the slots the same way
// and copies the staged value character by character. Each result first waits in
// a holding register so that run_last is known, then moves to the output register;
// a stalled receiver holds the sequencer only at its next emission or at the end
// of an item. Reset clears the table, the parser state and sets output_limit to
// 256. cfg_we writes output_limit; the user must assert it only while idle, and
// the block does not enforce this.
module variable_table_text_expander #(
	parameter int ENTRIES   = 16,
	parameter int NAME_LEN  = 8,
	parameter int VALUE_LEN = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [vtte_pkg::NAME_W-1:0]  name_chars,
	input  logic [vtte_pkg::LEN_W-1:0]   name_length,
	input  logic [vtte_pkg::CHAR_W-1:0]  character,
	input  logic                         final_req,
	input  logic                         cfg_we,
	input  logic [vtte_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [vtte_pkg::CHAR_W-1:0]  out_char,
	output logic                         char_valid,
	output logic                         run_last,
	output logic [2:0]                   status,
	output logic                         text_done,
	output logic [vtte_pkg::COUNT_W-1:0] output_count
);

	vtte_pkg::ctl_cmd_t cmd;
	vtte_pkg::dp_sts_t  sts;

	// The sequencer issues one command word per cycle and reads back status flags.
	vtte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.final_req (final_req),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath owns all storage: table, staging buffer, parser and result stage.
	vtte_dp #(
		.ENTRIES   (ENTRIES),
		.NAME_LEN  (NAME_LEN),
		.VALUE_LEN (VALUE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.name_chars   (name_chars),
		.name_length  (name_length),
		.character    (character),
		.final_req    (final_req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.run_last     (run_last),
		.status       (status),
		.text_done    (text_done),
		.output_count (output_count)
	);

endmodule

/* rtl/core/vtte_chk.sv */
// Port-level checks of the text expander and their attachment to the top level.
`timescale 1ns / 1ps
module vtte_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [vtte_pkg::CHAR_W-1:0]  out_char,
	input logic                         char_valid,
	input logic                         run_last,
	input logic [2:0]                   status,
	input logic                         text_done
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Character transfers carry a clean status and never end a text.
	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> (status == 3'd0) && !text_done)
		else $error("character transfer with status or end mark");

	// The ending transfer is always the last one of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("end of text or set not marked last");

	// A transfer without a character is an ending transfer with zero data.
	a_nochar_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> text_done && (out_char == '0))
		else $error("empty transfer that does not end a text or set");

endmodule

bind variable_table_text_expander vtte_chk u_vtte_chk (.*);
